// ----- rtl/modular_add_sub_mul_unit_top_assert.svh -----
// Assertion macros for the modular add/sub/mul unit.
// Included by the top level; the macros expand to nothing under synthesis.
`ifndef MODULAR_ADD_SUB_MUL_UNIT_TOP_ASSERT_SVH
`define MODULAR_ADD_SUB_MUL_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MAMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define MAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MAMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/mams_pkg.sv -----
// Shared types and constants of the modular add/sub/mul unit.
// No dependencies; used by mams_core, modular_add_sub_mul_unit_top and the testbench.
package mams_pkg;

    localparam int unsigned WIDTH_DEFAULT = 60;
    localparam int unsigned MODULUS_RESET = 2;
    localparam int unsigned MODULUS_MIN   = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2
    } t_cmd;

endpackage

// ----- rtl/mams_core.sv -----
// Arithmetic pipeline of the modular add/sub/mul unit: operand reduction,
// bit-serial modular multiply and the final add/sub/select stage.
// Depends on mams_pkg.
module mams_core #(
    parameter int unsigned WIDTH = mams_pkg::WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  mams_pkg::t_cmd     i_cmd,
    input  logic               i_last,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic [WIDTH-1:0]   i_modulus,
    output logic               o_valid,
    output logic               o_last,
    output logic [WIDTH-1:0]   o_result
);
    import mams_pkg::*;

    // Reduction stages: one remainder bit of a and b per stage.
    logic [WIDTH-1:0] r_rd_valid;
    t_cmd             r_rd_cmd  [WIDTH];
    logic             r_rd_last [WIDTH];
    logic [WIDTH-1:0] r_rd_a    [WIDTH];
    logic [WIDTH-1:0] r_rd_b    [WIDTH];
    logic [WIDTH-1:0] r_rd_ra   [WIDTH];
    logic [WIDTH-1:0] r_rd_rb   [WIDTH];
    logic [WIDTH-1:0] n_rd_ra   [WIDTH];
    logic [WIDTH-1:0] n_rd_rb   [WIDTH];

    // Multiply stages: one bit of reduced b per stage, most significant first.
    logic [WIDTH-1:0] r_mu_valid;
    t_cmd             r_mu_cmd  [WIDTH];
    logic             r_mu_last [WIDTH];
    logic [WIDTH-1:0] r_mu_a    [WIDTH];
    logic [WIDTH-1:0] r_mu_b    [WIDTH];
    logic [WIDTH-1:0] r_mu_m    [WIDTH];
    logic [WIDTH-1:0] n_mu_m    [WIDTH];

    logic             r_fin_valid;
    logic             r_fin_last;
    logic [WIDTH-1:0] r_fin_result;
    logic [WIDTH-1:0] n_fin_result;

    function automatic logic [WIDTH-1:0] f_shift_sub(
        input logic [WIDTH-1:0] r,
        input logic             bit_in,
        input logic [WIDTH-1:0] q
    );
        logic [WIDTH:0] t;
        t = {r, bit_in};
        if (t >= {1'b0, q}) begin
            t = t - {1'b0, q};
        end
        return t[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] f_dbl_add(
        input logic [WIDTH-1:0] m,
        input logic             add_en,
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] q
    );
        logic [WIDTH+1:0] s;
        logic [WIDTH+1:0] q1;
        logic [WIDTH+1:0] q2;
        s  = {1'b0, m, 1'b0} + {2'b00, (add_en ? a : {WIDTH{1'b0}})};
        q1 = {2'b00, q};
        q2 = {1'b0, q, 1'b0};
        if (s >= q2) begin
            s = s - q2;
        end else if (s >= q1) begin
            s = s - q1;
        end
        return s[WIDTH-1:0];
    endfunction

    always_comb begin
        n_rd_ra[0] = f_shift_sub({WIDTH{1'b0}}, i_a[WIDTH-1], i_modulus);
        n_rd_rb[0] = f_shift_sub({WIDTH{1'b0}}, i_b[WIDTH-1], i_modulus);
        for (int i = 1; i < WIDTH; i++) begin
            n_rd_ra[i] = f_shift_sub(r_rd_ra[i-1], r_rd_a[i-1][WIDTH-1-i], i_modulus);
            n_rd_rb[i] = f_shift_sub(r_rd_rb[i-1], r_rd_b[i-1][WIDTH-1-i], i_modulus);
        end
    end

    always_comb begin
        n_mu_m[0] = f_dbl_add({WIDTH{1'b0}}, r_rd_rb[WIDTH-1][WIDTH-1],
                              r_rd_ra[WIDTH-1], i_modulus);
        for (int i = 1; i < WIDTH; i++) begin
            n_mu_m[i] = f_dbl_add(r_mu_m[i-1], r_mu_b[i-1][WIDTH-1-i],
                                  r_mu_a[i-1], i_modulus);
        end
    end

    always_comb begin
        logic [WIDTH:0]   sum;
        logic [WIDTH-1:0] add_res;
        logic [WIDTH-1:0] sub_res;
        logic [WIDTH-1:0] fa;
        logic [WIDTH-1:0] fb;
        fa  = r_mu_a[WIDTH-1];
        fb  = r_mu_b[WIDTH-1];
        sum = {1'b0, fa} + {1'b0, fb};
        if (sum >= {1'b0, i_modulus}) begin
            sum = sum - {1'b0, i_modulus};
        end
        add_res = sum[WIDTH-1:0];
        sub_res = (fa >= fb) ? (fa - fb) : (fa - fb + i_modulus);
        case (r_mu_cmd[WIDTH-1])
            CMD_ADD: n_fin_result = add_res;
            CMD_SUB: n_fin_result = sub_res;
            CMD_MUL: n_fin_result = r_mu_m[WIDTH-1];
            default: n_fin_result = '0;
        endcase
        if (i_modulus < WIDTH'(MODULUS_MIN)) begin
            n_fin_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= '0;
            r_mu_valid  <= '0;
            r_fin_valid <= 1'b0;
        end else if (i_ce) begin
            r_rd_valid  <= {r_rd_valid[WIDTH-2:0], i_valid};
            r_mu_valid  <= {r_mu_valid[WIDTH-2:0], r_rd_valid[WIDTH-1]};
            r_fin_valid <= r_mu_valid[WIDTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rd_cmd[0]  <= i_cmd;
            r_rd_last[0] <= i_last;
            r_rd_a[0]    <= i_a;
            r_rd_b[0]    <= i_b;
            r_rd_ra[0]   <= n_rd_ra[0];
            r_rd_rb[0]   <= n_rd_rb[0];
            for (int i = 1; i < WIDTH; i++) begin
                r_rd_cmd[i]  <= r_rd_cmd[i-1];
                r_rd_last[i] <= r_rd_last[i-1];
                r_rd_a[i]    <= r_rd_a[i-1];
                r_rd_b[i]    <= r_rd_b[i-1];
                r_rd_ra[i]   <= n_rd_ra[i];
                r_rd_rb[i]   <= n_rd_rb[i];
            end
            r_mu_cmd[0]  <= r_rd_cmd[WIDTH-1];
            r_mu_last[0] <= r_rd_last[WIDTH-1];
            r_mu_a[0]    <= r_rd_ra[WIDTH-1];
            r_mu_b[0]    <= r_rd_rb[WIDTH-1];
            r_mu_m[0]    <= n_mu_m[0];
            for (int i = 1; i < WIDTH; i++) begin
                r_mu_cmd[i]  <= r_mu_cmd[i-1];
                r_mu_last[i] <= r_mu_last[i-1];
                r_mu_a[i]    <= r_mu_a[i-1];
                r_mu_b[i]    <= r_mu_b[i-1];
                r_mu_m[i]    <= n_mu_m[i];
            end
            r_fin_last   <= r_mu_last[WIDTH-1];
            r_fin_result <= n_fin_result;
        end
    end

    assign o_valid  = r_fin_valid;
    assign o_last   = r_fin_last;
    assign o_result = r_fin_result;

endmodule

// ----- rtl/modular_add_sub_mul_unit_top.sv -----
// Top level of the modular add/sub/mul unit: stream ports, modulus register
// and output skid buffer. Depends on mams_pkg, mams_core and the assert header.
//
// Usage: configure the modulus through i_cfg_wr_en / i_cfg_wr_data while the
// unit is empty, then stream words on s_axis. Each word carries operand a and
// operand b in tdata, the operation code in tuser (add, subtract, multiply)
// and the end-of-vector mark in tlast. Each input word yields exactly one
// output word on m_axis with the modular result in tdata and the same tlast.
// WIDTH stages reduce a and b by shift-and-subtract, WIDTH stages run the
// double-and-add multiplier, one stage selects the result and one is the
// output register. Throughput is one word per cycle while the pipeline is
// not frozen by a stall on m_axis. Results leave in input order.
// Reset clears all valid bits and sets the modulus to 2.
// When m_axis_tready is low the output word holds; one more word is caught
// in a skid register, after which s_axis_tready drops and the whole pipeline
// freezes until the receiver takes the held word.
// Unused operation codes and a modulus below 2 give a result of zero.
`include "modular_add_sub_mul_unit_top_assert.svh"

module modular_add_sub_mul_unit_top #(
    parameter int unsigned WIDTH = mams_pkg::WIDTH_DEFAULT,
    localparam int unsigned S_TDATA_W = ((2 * WIDTH + 7) / 8) * 8,
    localparam int unsigned M_TDATA_W = ((WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [WIDTH-1:0]     i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // operand_a, operand_b, zero pad
    input  logic [1:0]           s_axis_tuser,   // cmd
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // result, zero pad
    output logic                 m_axis_tlast
);
    import mams_pkg::*;

    logic [WIDTH-1:0] r_modulus;
    logic             ce;
    logic             core_valid;
    logic             core_last;
    logic [WIDTH-1:0] core_result;

    logic             r_out_valid;
    logic             r_out_last;
    logic [WIDTH-1:0] r_out_result;
    logic             r_skid_valid;
    logic             r_skid_last;
    logic [WIDTH-1:0] r_skid_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(MODULUS_RESET);
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    assign ce            = !r_skid_valid;
    assign s_axis_tready = ce;

    mams_core #(
        .WIDTH(WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (ce),
        .i_valid   (s_axis_tvalid),
        .i_cmd     (t_cmd'(s_axis_tuser)),
        .i_last    (s_axis_tlast),
        .i_a       (s_axis_tdata[WIDTH-1:0]),
        .i_b       (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .i_modulus (r_modulus),
        .o_valid   (core_valid),
        .o_last    (core_last),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= core_valid;
            end
        end else if (core_valid && ce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_last   <= r_skid_last;
                r_out_result <= r_skid_result;
            end else begin
                r_out_last   <= core_last;
                r_out_result <= core_result;
            end
        end else if (core_valid && ce) begin
            r_skid_last   <= core_last;
            r_skid_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = M_TDATA_W'(r_out_result);

    `MAMS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid register holds a word while the output register is empty")
    `MAMS_ASSERT_NEXT(a_skid_catches, i_clk, i_rst_n,
        r_out_valid && !m_axis_tready && core_valid && ce, r_skid_valid,
        "word leaving the pipeline during a stall was not caught")
    `MAMS_ASSERT_NOW(a_result_reduced, i_clk, i_rst_n,
        r_out_valid && (r_modulus >= WIDTH'(MODULUS_MIN)), r_out_result < r_modulus,
        "result is not below the modulus")

endmodule

// ----- sim/modular_add_sub_mul_unit_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for modular_add_sub_mul_unit_top: directed rows, then random
// vectors under many moduli, with random gaps on both stream sides.
// Depends on mams_pkg and the unit's RTL.
module modular_add_sub_mul_unit_top_test;
    import mams_pkg::*;

    localparam int W = 60;
    localparam int S_W = 120;
    localparam int M_W = 64;
    localparam int LATENCY = 2 * W + 2;
    localparam int STALL_LIMIT = 4000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [W-1:0] MAX_VAL = 60'hFFF_FFFF_FFFF_FFFF;
    localparam logic [W-1:0] Q_BIG = 60'h800_0000_0000_001D;

    typedef struct packed {
        logic [W-1:0] residue;
        logic         last;
    } t_expected;

    typedef struct packed {
        logic         set_q;
        logic [W-1:0] q;
        logic [1:0]   cmd;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic         last;
        logic         known;
        logic [W-1:0] want;
    } t_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [W-1:0]   i_cfg_wr_data = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata = '0;    // operand_a, operand_b
    logic [1:0]     s_axis_tuser = '0;    // cmd
    logic           s_axis_tlast = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;         // result, zero pad
    logic           m_axis_tlast;

    t_expected    pending_results[$];
    t_expected    head;
    logic [W-1:0] modulus_now = W'(MODULUS_RESET);
    bit           steady_run = 1'b0;
    int           error_count = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           settings_used = 1;
    int           stall_cycles = 0;
    int           hold_left = 0;

    t_row dir_rows [0:22] = '{
        '{1'b0, '0, CMD_ADD, 60'd1, 60'd1, 1'b0, 1'b1, 60'd0},
        '{1'b0, '0, CMD_MUL, 60'd1, MAX_VAL, 1'b0, 1'b1, 60'd1},
        '{1'b0, '0, CMD_SUB, 60'd0, 60'd1, 1'b1, 1'b1, 60'd1},
        '{1'b1, MAX_VAL, CMD_ADD, MAX_VAL - 1, MAX_VAL - 1, 1'b0, 1'b1, MAX_VAL - 2},
        '{1'b0, '0, CMD_SUB, 60'd0, 60'd1, 1'b0, 1'b1, MAX_VAL - 1},
        '{1'b0, '0, CMD_MUL, MAX_VAL - 1, MAX_VAL - 1, 1'b0, 1'b1, 60'd1},
        '{1'b0, '0, CMD_ADD, MAX_VAL, 60'd0, 1'b0, 1'b1, 60'd0},
        '{1'b0, '0, CMD_MUL, 60'd0, MAX_VAL, 1'b0, 1'b1, 60'd0},
        '{1'b0, '0, CMD_RESERVED, 60'd5, 60'd7, 1'b1, 1'b1, 60'd0},
        '{1'b0, '0, CMD_SUB, MAX_VAL - 1, MAX_VAL, 1'b0, 1'b1, MAX_VAL - 1},
        '{1'b1, 60'd0, CMD_MUL, MAX_VAL, MAX_VAL, 1'b0, 1'b1, 60'd0},
        '{1'b0, '0, CMD_ADD, 60'd3, 60'd4, 1'b1, 1'b1, 60'd0},
        '{1'b1, 60'd1, CMD_SUB, 60'd0, 60'd1, 1'b0, 1'b1, 60'd0},
        '{1'b0, '0, CMD_MUL, MAX_VAL, MAX_VAL, 1'b1, 1'b1, 60'd0},
        '{1'b1, 60'd3, CMD_ADD, 60'd2, 60'd2, 1'b0, 1'b1, 60'd1},
        '{1'b0, '0, CMD_MUL, 60'd2, 60'd2, 1'b0, 1'b1, 60'd1},
        '{1'b0, '0, CMD_SUB, 60'd1, 60'd2, 1'b0, 1'b1, 60'd2},
        '{1'b0, '0, CMD_MUL, MAX_VAL, MAX_VAL, 1'b1, 1'b0, 60'd0},
        '{1'b1, Q_BIG, CMD_MUL, 60'h7FF_FFFF_FFFF_FFFF, 60'hAAA_AAAA_AAAA_AAAA,
          1'b0, 1'b0, 60'd0},
        '{1'b0, '0, CMD_ADD, Q_BIG - 1, 60'h555_5555_5555_5555, 1'b0, 1'b0, 60'd0},
        '{1'b0, '0, CMD_SUB, 60'h123_4567_89AB_CDEF, MAX_VAL, 1'b0, 1'b0, 60'd0},
        '{1'b0, '0, CMD_MUL, Q_BIG - 1, Q_BIG + 1, 1'b1, 1'b0, 60'd0},
        '{1'b0, '0, CMD_RESERVED, MAX_VAL, MAX_VAL, 1'b1, 1'b1, 60'd0}
    };

    modular_add_sub_mul_unit_top #(
        .WIDTH(W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    function automatic logic [W-1:0] modular_result(input logic [1:0] cmd,
                                                    input logic [W-1:0] a,
                                                    input logic [W-1:0] b,
                                                    input logic [W-1:0] q);
        logic [2*W-1:0] qq;
        logic [2*W-1:0] ar;
        logic [2*W-1:0] br;
        logic [2*W-1:0] r;
        if (q < 2) begin
            return '0;
        end
        qq = {{W{1'b0}}, q};
        ar = a % qq;
        br = b % qq;
        case (cmd)
            CMD_ADD: r = (ar + br) % qq;
            CMD_SUB: r = (ar + qq - br) % qq;
            CMD_MUL: r = (ar * br) % qq;
            default: r = '0;
        endcase
        return r[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand60();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_below(input logic [W-1:0] q);
        return (q >= 2) ? rand60() % q : rand60();
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [W-1:0] pick_modulus(input int kind);
        logic [W-1:0] q;
        case (kind)
            0: q = MAX_VAL;
            1: q = 60'd2;
            2: q = rand60() | {1'b1, {(W-1){1'b0}}};
            3: q = W'($urandom_range(3, 255));
            4: q = rand60();
            5: q = W'($urandom_range(0, 1));
            6: q = 60'($urandom) + 60'd2;
            7: q = MAX_VAL - W'($urandom_range(0, 1000));
            default: q = W'($urandom_range(2, 16));
        endcase
        if (kind != 5 && q < 2) begin
            q = 60'd2;
        end
        return q;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [W-1:0] a,
                             input logic [W-1:0] b, input logic last,
                             input logic known, input logic [W-1:0] want);
        t_expected e;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        e.residue = known ? want : modular_result(cmd, a, b, modulus_now);
        e.last = last;
        pending_results.push_back(e);
        words_sent++;
    endtask

    task automatic pause_sender();
        int n;
        n = (steady_run || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic set_modulus(input logic [W-1:0] q);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= q;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        modulus_now = q;
        settings_used++;
    endtask

    task automatic send_random();
        logic [1:0]   c;
        logic [W-1:0] a;
        logic [W-1:0] b;
        int           sel;
        sel = $urandom_range(0, 15);
        c = (sel < 5) ? CMD_ADD : (sel < 10) ? CMD_SUB : (sel < 15) ? CMD_MUL : CMD_RESERVED;
        case ($urandom_range(0, 9))
            0: a = '0;
            1: a = modulus_now - 1;
            2: a = rand60();
            3: a = MAX_VAL;
            default: a = rand_below(modulus_now);
        endcase
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = modulus_now - 1;
            2: b = modulus_now;
            3: b = MAX_VAL;
            4, 5, 6: b = rand60();
            default: b = rand_below(modulus_now);
        endcase
        send_word(c, a, b, $urandom_range(0, 7) == 0, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result word %h with nothing expected", m_axis_tdata));
            end else begin
                head = pending_results.pop_front();
                if (m_axis_tdata[W-1:0] !== head.residue) begin
                    flag_mismatch($sformatf("result %h, expected %h",
                                            m_axis_tdata[W-1:0], head.residue));
                end
                if (m_axis_tlast !== head.last) begin
                    flag_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, head.last));
                end
                words_checked++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (steady_run) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                hold_left = $urandom_range(0, 8);
            end else begin
                m_axis_tready <= 1'b0;
                hold_left = pick_gap() - 1;
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Run stalled for %0d cycles with %0d results outstanding.",
                 STALL_LIMIT, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int directed_count;
        int n_items;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_q) begin
                set_modulus(dir_rows[i].q);
            end
            send_word(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].want);
            pause_sender();
        end
        directed_count = words_sent;
        for (int ph = 0; ph < 9; ph++) begin
            set_modulus(pick_modulus(ph));
            steady_run = ($urandom_range(0, 3) == 0);
            n_items = (ph == 5) ? 40 : 195;
            repeat (n_items) begin
                send_random();
                pause_sender();
            end
            steady_run = 1'b0;
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("Sent %0d words (%0d directed) under %0d modulus settings, checked %0d results.",
                 words_sent, directed_count, settings_used, words_checked);
        $display("Mismatches found: %0d.", error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
